// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the event timebase.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/mspet_pkg.sv =====
// Shared constants and types of the multi-slot periodic event timebase.
package mspet_pkg;

    // Slot and register counts
    localparam int SLOT_COUNT  = 4;
    localparam int PERIOD_REGS = 4;

    // Field widths
    localparam int OP_W        = 2;
    localparam int IDX_W       = 3;
    localparam int PERIOD_W    = 16;
    localparam int COUNT_W     = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Register indexes; periods follow the first one in order
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PENDING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0    = 3'd1;

    // Per-slot command from the sequencing logic
    typedef struct packed {
        logic tick;
        logic clear;
        logic take;
    } slot_cmd_t;

endpackage

// ===== rtl/mspet_slot.sv =====
// One event slot: elapsed-tick counter and saturating pending-event counter.
module mspet_slot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mspet_pkg::slot_cmd_t           cmd,
    input  logic [mspet_pkg::PERIOD_W-1:0] period,
    input  logic [mspet_pkg::COUNT_W-1:0]  limit,
    output logic [mspet_pkg::COUNT_W-1:0]  pending
);

    logic [mspet_pkg::PERIOD_W-1:0] elapsed_reg;
    logic [mspet_pkg::PERIOD_W-1:0] elapsed_next;
    logic [mspet_pkg::COUNT_W-1:0]  pending_reg;
    logic [mspet_pkg::COUNT_W-1:0]  pending_next;
    logic [mspet_pkg::PERIOD_W-1:0] elapsed_inc;
    logic                           fire;

    // Increment wraps at the counter width; a lowered period fires at once
    assign elapsed_inc = elapsed_reg + mspet_pkg::PERIOD_W'(1);
    assign fire        = (elapsed_inc >= period);

    // Next-state logic
    always_comb
    begin
        elapsed_next = elapsed_reg;
        pending_next = pending_reg;
        if (cmd.clear)
        begin
            elapsed_next = '0;
            pending_next = '0;
        end
        else if (cmd.tick && (period != '0))
        begin
            if (fire)
            begin
                elapsed_next = '0;
                // saturate; a count already above a lowered limit is kept
                if (pending_reg < limit)
                begin
                    pending_next = pending_reg + mspet_pkg::COUNT_W'(1);
                end
            end
            else
            begin
                elapsed_next = elapsed_inc;
            end
        end
        else if (cmd.take)
        begin
            pending_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            pending_reg <= pending_next;
        end
    end

    assign pending = pending_reg;

endmodule

// ===== rtl/multi_slot_periodic_event_timebase_top.sv =====
// Top level of the multi-slot periodic event timebase.
// An accepted request passes from the input register through one pass of slot logic into
// the result register; a stalled result delays it.
// Throughput: one request per cycle unless the result stalls; all slots update in one pass.
// Reset: asynchronous, active low; clears all counters, periods to 0, maximum to 1.
// Configuration writes take effect at the next edge and leave counters untouched.
module multi_slot_periodic_event_timebase_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [mspet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mspet_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mspet_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // operation[1:0], slot_index[4:2]
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mspet_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // pending_count[7:0]
);

    // Configuration registers
    logic [mspet_pkg::COUNT_W-1:0]  max_pending_reg;
    logic [mspet_pkg::PERIOD_W-1:0] period_reg [mspet_pkg::PERIOD_REGS];

    // Input register
    logic                          in_valid_reg;
    logic [mspet_pkg::OP_W-1:0]    in_op_reg;
    logic [mspet_pkg::IDX_W-1:0]   in_idx_reg;

    // Result register
    logic                          out_valid_reg;
    logic [mspet_pkg::COUNT_W-1:0] out_data_reg;
    logic [mspet_pkg::COUNT_W-1:0] out_data_next;

    logic                          accept;
    logic                          advance;
    logic [mspet_pkg::COUNT_W-1:0] limit;

    mspet_pkg::slot_cmd_t           slot_cmd     [mspet_pkg::SLOT_COUNT];
    logic [mspet_pkg::PERIOD_W-1:0] slot_period  [mspet_pkg::SLOT_COUNT];
    logic [mspet_pkg::COUNT_W-1:0]  slot_pending [mspet_pkg::SLOT_COUNT];

    // Configuration writes; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pending_reg <= mspet_pkg::COUNT_W'(1);
            for (int p = 0; p < mspet_pkg::PERIOD_REGS; p++)
            begin
                period_reg[p] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == mspet_pkg::REG_MAX_PENDING)
            begin
                max_pending_reg <= cfg_data[mspet_pkg::COUNT_W-1:0];
            end
            for (int p = 0; p < mspet_pkg::PERIOD_REGS; p++)
            begin
                if (cfg_index == (mspet_pkg::REG_PERIOD_0 + mspet_pkg::CFG_IDX_W'(p)))
                begin
                    period_reg[p] <= cfg_data[mspet_pkg::PERIOD_W-1:0];
                end
            end
        end
    end

    // A maximum of zero acts as one
    assign limit = (max_pending_reg == '0) ? mspet_pkg::COUNT_W'(1) : max_pending_reg;

    // Handshake: the request moves on when the result register is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg  <= s_axis_tdata[mspet_pkg::OP_W-1:0];
            in_idx_reg <= s_axis_tdata[mspet_pkg::OP_W +: mspet_pkg::IDX_W];
        end
    end

    // Slots; those without a period register stay disabled
    for (genvar s = 0; s < mspet_pkg::SLOT_COUNT; s++)
    begin : g_slot
        if (s < mspet_pkg::PERIOD_REGS)
        begin : g_per
            assign slot_period[s] = period_reg[s];
        end
        else
        begin : g_noper
            assign slot_period[s] = '0;
        end

        assign slot_cmd[s].tick  = advance && (in_op_reg == mspet_pkg::OP_TICK);
        assign slot_cmd[s].clear = advance && (in_op_reg == mspet_pkg::OP_CLEAR);
        assign slot_cmd[s].take  = advance && (in_op_reg == mspet_pkg::OP_CONSUME)
                                   && (in_idx_reg == mspet_pkg::IDX_W'(s));

        mspet_slot u_slot (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (slot_cmd[s]),
            .period  (slot_period[s]),
            .limit   (limit),
            .pending (slot_pending[s])
        );
    end

    // Result: pending count of the consumed slot, zero otherwise
    always_comb
    begin
        out_data_next = '0;
        for (int s = 0; s < mspet_pkg::SLOT_COUNT; s++)
        begin
            if (slot_cmd[s].take)
            begin
                out_data_next = out_data_next | slot_pending[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/mspet_checker.sv =====
// Port-level checker for the event timebase, bound to the top level.
`include "assert_macros.svh"

module mspet_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [mspet_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [mspet_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // no result is offered while reset is held
    `CHK_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !m_axis_tvalid, "result during reset")

    // a stalled result keeps its value
    `CHK_ASSERT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // a fresh result follows a request that was taken into the input register before it
    `CHK_ASSERT(a_result_has_request, clk, rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without request")

    // only a consume can return a nonzero count
    `CHK_ASSERT(a_zero_unless_consume, clk, rst_n, $rose(m_axis_tvalid) && ($past(s_axis_tdata[mspet_pkg::OP_W-1:0], 2) != mspet_pkg::OP_CONSUME) |-> (m_axis_tdata == '0), "nonzero count for non-consume")

endmodule

bind multi_slot_periodic_event_timebase_top mspet_checker u_mspet_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench of the multi-slot periodic event timebase, with its own slot predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_STALL    = 200;

    // Codes the package does not name
    localparam logic [mspet_pkg::OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [mspet_pkg::CFG_IDX_W-1:0] REG_BEYOND =
        mspet_pkg::CFG_IDX_W'(mspet_pkg::REG_PERIOD_0 + mspet_pkg::PERIOD_REGS);

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [mspet_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [mspet_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [mspet_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // operation[1:0], slot_index[4:2]
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [mspet_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // pending_count[7:0]

    // Predictor state: configuration copy and slot counters
    logic [mspet_pkg::COUNT_W-1:0]  max_pending_reg;
    logic [mspet_pkg::PERIOD_W-1:0] period_reg [mspet_pkg::PERIOD_REGS];
    logic [mspet_pkg::PERIOD_W-1:0] elapsed_cnt [mspet_pkg::SLOT_COUNT];
    logic [mspet_pkg::COUNT_W-1:0]  pending_cnt [mspet_pkg::SLOT_COUNT];

    logic [mspet_pkg::COUNT_W-1:0] expected_counts [$];
    int                            error_count;
    int                            cycle_count;
    int                            rx_stall_left;
    bit                            idle_enabled;

    multi_slot_periodic_event_timebase_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Clears the predictor to its reset state
    task automatic clear_predictor();
        begin
            max_pending_reg = 8'd1;
            for (int i = 0; i < mspet_pkg::PERIOD_REGS; i++)
                period_reg[i] = '0;
            for (int s = 0; s < mspet_pkg::SLOT_COUNT; s++)
            begin
                elapsed_cnt[s] = '0;
                pending_cnt[s] = '0;
            end
        end
    endtask

    // Works out the pending count a request returns and updates the slot counters
    function automatic logic [mspet_pkg::COUNT_W-1:0] predict_pending(
        logic [mspet_pkg::OP_W-1:0]  op,
        logic [mspet_pkg::IDX_W-1:0] idx);
        logic [mspet_pkg::COUNT_W-1:0]  taken;
        logic [mspet_pkg::COUNT_W-1:0]  cap;
        logic [mspet_pkg::PERIOD_W-1:0] per;
        logic [mspet_pkg::PERIOD_W-1:0] next_elapsed;
        taken = '0;
        case (op)
            mspet_pkg::OP_TICK:
            begin
                cap = (max_pending_reg == '0) ? 8'd1 : max_pending_reg;
                for (int s = 0; s < mspet_pkg::SLOT_COUNT; s++)
                begin
                    per = (s < mspet_pkg::PERIOD_REGS) ? period_reg[s] : '0;
                    if (per != '0)
                    begin
                        next_elapsed = elapsed_cnt[s] + 16'd1;
                        if (next_elapsed < per)
                            elapsed_cnt[s] = next_elapsed;
                        else
                        begin
                            elapsed_cnt[s] = '0;
                            if (pending_cnt[s] < cap)
                                pending_cnt[s] = pending_cnt[s] + 8'd1;
                        end
                    end
                end
            end
            mspet_pkg::OP_CONSUME:
            begin
                if (idx < mspet_pkg::SLOT_COUNT)
                begin
                    taken = pending_cnt[idx];
                    pending_cnt[idx] = '0;
                end
            end
            mspet_pkg::OP_CLEAR:
            begin
                for (int s = 0; s < mspet_pkg::SLOT_COUNT; s++)
                begin
                    elapsed_cnt[s] = '0;
                    pending_cnt[s] = '0;
                end
            end
            default:
            begin
            end
        endcase
        return taken;
    endfunction

    // Mismatch report
    task automatic report_mismatch(string what, int exp_val, int got_val);
        begin
            $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                     cycle_count, what, exp_val, got_val);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        logic [mspet_pkg::COUNT_W-1:0] exp_count;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_counts.size() == 0)
                report_mismatch("result with no request outstanding", 0,
                                int'(m_axis_tdata));
            else
            begin
                exp_count = expected_counts.pop_front();
                if (m_axis_tdata !== exp_count)
                    report_mismatch("pending_count", int'(exp_count), int'(m_axis_tdata));
            end
        end
    end

    // Result receiver: random stall bursts, plus long hold-offs on demand
    initial
    begin : result_receiver
        int burst;
        burst = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall_left--;
            end
            else if (burst > 0)
            begin
                m_axis_tready <= 1'b0;
                burst--;
            end
            else if (idle_enabled && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Sends one request, with an optional idle burst ahead of it
    task automatic send_request(logic [mspet_pkg::OP_W-1:0] op,
                                logic [mspet_pkg::IDX_W-1:0] idx);
        int gap;
        begin
            if (idle_enabled && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 4);
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {3'b000, idx, op};
            do
                @(posedge clk);
            while (!s_axis_tready);
            expected_counts.push_back(predict_pending(op, idx));
        end
    endtask

    // Random request: mostly ticks and consumes, some clears and unused codes
    task automatic send_random_request();
        int                           r;
        logic [mspet_pkg::OP_W-1:0]   op;
        logic [mspet_pkg::IDX_W-1:0]  idx;
        begin
            r = $urandom_range(0, 99);
            if (r < 58)
                op = mspet_pkg::OP_TICK;
            else if (r < 88)
                op = mspet_pkg::OP_CONSUME;
            else if (r < 94)
                op = mspet_pkg::OP_CLEAR;
            else
                op = OP_UNUSED;
            if (op == mspet_pkg::OP_CONSUME && $urandom_range(0, 4) != 0)
                idx = mspet_pkg::IDX_W'($urandom_range(0, mspet_pkg::SLOT_COUNT - 1));
            else
                idx = mspet_pkg::IDX_W'($urandom_range(0, 7));
            send_request(op, idx);
        end
    endtask

    // Stops the request stream and waits until every result has arrived
    task automatic settle();
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            while (expected_counts.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // One register write; only called while the block is idle
    task automatic write_reg(logic [mspet_pkg::CFG_IDX_W-1:0] idx,
                             logic [mspet_pkg::CFG_DATA_W-1:0] data);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            if (idx == mspet_pkg::REG_MAX_PENDING)
                max_pending_reg = data[mspet_pkg::COUNT_W-1:0];
            else if (idx >= mspet_pkg::REG_PERIOD_0 && idx < REG_BEYOND)
                period_reg[idx - mspet_pkg::REG_PERIOD_0] = data;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Period register index of a slot
    function automatic logic [mspet_pkg::CFG_IDX_W-1:0] period_index(int s);
        return mspet_pkg::CFG_IDX_W'(mspet_pkg::REG_PERIOD_0 + s);
    endfunction

    // Writes all registers with a fresh random setting, extremes included
    task automatic write_random_settings();
        int                             r;
        logic [mspet_pkg::PERIOD_W-1:0] per;
        begin
            r = $urandom_range(0, 5);
            case (r)
                0: write_reg(mspet_pkg::REG_MAX_PENDING, 16'd0);
                1: write_reg(mspet_pkg::REG_MAX_PENDING, 16'd1);
                2: write_reg(mspet_pkg::REG_MAX_PENDING, 16'd255);
                default: write_reg(mspet_pkg::REG_MAX_PENDING, 16'($urandom_range(0, 255)));
            endcase
            for (int s = 0; s < mspet_pkg::PERIOD_REGS; s++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    per = 16'd0;
                else if (r == 1)
                    per = 16'hFFFF;
                else if (r == 2)
                    per = 16'($urandom_range(0, 65535));
                else
                    per = 16'($urandom_range(1, 12));
                write_reg(period_index(s), per);
            end
        end
    endtask

    // Reset defaults: nothing pending, all slots disabled
    task automatic test_reset_state();
        begin
            for (int s = 0; s < mspet_pkg::SLOT_COUNT; s++)
                send_request(mspet_pkg::OP_CONSUME, mspet_pkg::IDX_W'(s));
            send_request(mspet_pkg::OP_TICK, 3'd7);
            send_request(OP_UNUSED, 3'd5);
            send_request(mspet_pkg::OP_CONSUME, 3'd7);
            settle();
        end
    endtask

    // Directed corner cases: zero maximum, lowered maximum and period, clear, range
    task automatic test_directed_cases();
        begin
            write_reg(mspet_pkg::REG_MAX_PENDING, 16'd0);
            write_reg(period_index(0), 16'd1);
            write_reg(period_index(1), 16'd2);
            write_reg(period_index(2), 16'hFFFF);
            write_reg(period_index(3), 16'd0);
            write_reg(REG_BEYOND, 16'hFFFF);
            send_request(mspet_pkg::OP_TICK, 3'd0);
            send_request(mspet_pkg::OP_TICK, 3'd5);
            send_request(mspet_pkg::OP_TICK, 3'd2);
            send_request(mspet_pkg::OP_CONSUME, 3'd0);
            send_request(mspet_pkg::OP_CONSUME, 3'd1);
            send_request(mspet_pkg::OP_CONSUME, 3'd3);
            settle();
            write_reg(mspet_pkg::REG_MAX_PENDING, 16'd255);
            write_reg(period_index(1), 16'd10);
            repeat (4) send_request(mspet_pkg::OP_TICK, 3'd0);
            settle();
            // maximum lowered below the pending count, period lowered below elapsed
            write_reg(mspet_pkg::REG_MAX_PENDING, 16'd2);
            write_reg(period_index(1), 16'd1);
            send_request(mspet_pkg::OP_TICK, 3'd6);
            send_request(mspet_pkg::OP_CONSUME, 3'd0);
            send_request(mspet_pkg::OP_CONSUME, 3'd1);
            send_request(mspet_pkg::OP_CLEAR, 3'd7);
            send_request(mspet_pkg::OP_CONSUME, 3'd2);
            send_request(mspet_pkg::OP_CONSUME, 3'd4);
            settle();
        end
    endtask

    // Pending count runs into the 8-bit ceiling
    task automatic test_saturation();
        begin
            write_reg(mspet_pkg::REG_MAX_PENDING, 16'd255);
            write_reg(period_index(0), 16'd1);
            write_reg(period_index(1), 16'd2);
            for (int i = 0; i < 280; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_request(OP_UNUSED, mspet_pkg::IDX_W'($urandom_range(0, 7)));
                else
                    send_request(mspet_pkg::OP_TICK, mspet_pkg::IDX_W'($urandom_range(0, 7)));
            end
            for (int s = 0; s < mspet_pkg::SLOT_COUNT; s++)
                send_request(mspet_pkg::OP_CONSUME, mspet_pkg::IDX_W'(s));
            settle();
        end
    endtask

    // Random phases, each under its own register setting
    task automatic test_random_phases(int phases, int per_phase);
        begin
            for (int p = 0; p < phases; p++)
            begin
                write_random_settings();
                for (int i = 0; i < per_phase; i++)
                    send_random_request();
                settle();
            end
        end
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        begin
            write_random_settings();
            rx_stall_left = LONG_STALL;
            for (int i = 0; i < 60; i++)
                send_random_request();
            settle();
        end
    endtask

    // Closing stretch with both sides running flat out
    task automatic test_full_rate();
        begin
            idle_enabled = 1'b0;
            write_random_settings();
            for (int i = 0; i < 300; i++)
                send_random_request();
            settle();
        end
    endtask

    // Test sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        rx_stall_left = 0;
        idle_enabled  = 1'b1;
        clear_predictor();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_cases();
        test_saturation();
        test_random_phases(6, 200);
        test_backpressure();
        test_random_phases(1, 200);
        test_full_rate();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
